FILE: rtl/bba_pkg.sv
package bba_pkg;

    localparam int ADDR_BITS  = 20;
    localparam int MAX_LEVELS = 12;

    // widths that follow from the pool geometry
    localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
    localparam int MASK_W  = MAX_LEVELS + 1;
    localparam int NODE_W  = MAX_LEVELS + 1;
    localparam int SLOT_W  = MAX_LEVELS;
    localparam int GL_W    = 5;
    localparam int LOG_W   = 5;
    localparam int HDR_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 7;

    localparam int MARK_DEPTH = 1 << NODE_W;
    localparam int GL_DEPTH   = 1 << SLOT_W;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_POOL_LOG2 = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_LOG2  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_HEADER    = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    // effective configuration after clamping
    typedef struct packed {
        logic [LOG_W-1:0] pool_log2;
        logic [LOG_W-1:0] min_log2;
        logic [LVL_W-1:0] lmax;
        logic [HDR_W-1:0] hdr;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [MASK_W-1:0] wdata;
        logic [NODE_W-1:0] raddr;
    } t_mark_req;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [GL_W-1:0]   wdata;
        logic [SLOT_W-1:0] raddr;
    } t_gl_req;

endpackage

FILE: rtl/bba_ram.sv
module bba_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/bba_ctrl.sv
module bba_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bba_pkg::t_cfg                  i_cfg,
    input  logic                           i_clear,
    input  logic                           i_start,
    input  logic                           i_opcode,
    input  logic [bba_pkg::ADDR_BITS-1:0]  i_request_length,
    input  logic [bba_pkg::ADDR_BITS-1:0]  i_data_offset,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [bba_pkg::ADDR_BITS-1:0]  o_granted_offset,
    output bba_pkg::t_mark_req             o_mark,
    input  logic [bba_pkg::MASK_W-1:0]     i_mark_rdata,
    output bba_pkg::t_gl_req               o_gl,
    input  logic [bba_pkg::GL_W-1:0]       i_gl_rdata
);
    import bba_pkg::*;

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_A_CHK = 13'b0000000000100,
        S_D_RD  = 13'b0000000001000,
        S_D_CHK = 13'b0000000010000,
        S_S_WC  = 13'b0000000100000,
        S_S_WS  = 13'b0000001000000,
        S_F_CHK = 13'b0000010000000,
        S_M_RD  = 13'b0000100000000,
        S_M_CHK = 13'b0001000000000,
        S_M_FIN = 13'b0010000000000,
        S_U_RD  = 13'b0100000000000,
        S_U_WR  = 13'b1000000000000
    } t_state;

    // bits lo+1 .. hi set: subtree summary of a split chain node
    function automatic logic [MASK_W-1:0] chain_mask(input logic [LVL_W-1:0] lo,
                                                     input logic [LVL_W-1:0] hi);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < MASK_W; k++) begin
            m[k] = (LVL_W'(k) > lo) && (LVL_W'(k) <= hi);
        end
        return m;
    endfunction

    t_state                r_state, n_state;
    logic [NODE_W-1:0]     r_cnt, n_cnt;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [NODE_W-1:0]     r_fnode, n_fnode;
    logic [LVL_W-1:0]      r_lv, n_lv;
    logic [LVL_W-1:0]      r_target, n_target;
    logic [LVL_W-1:0]      r_found, n_found;
    logic [MASK_W-1:0]     r_cur, n_cur;
    logic [ADDR_BITS-1:0]  r_base, n_base;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [ADDR_BITS-1:0]  r_res_off, n_res_off;
    logic                  r_done, n_done;
    logic [1:0]            r_status, n_status;
    logic [ADDR_BITS-1:0]  r_off, n_off;

    logic [ADDR_BITS:0]    need, pool_bytes;
    logic [LVL_W-1:0]      tgt;
    logic                  too_large;
    logic [ADDR_BITS-1:0]  fbase;
    logic [SLOT_W-1:0]     fslot;
    logic                  fbad;
    logic [LVL_W-1:0]      fnd;
    logic                  fnd_any;
    logic [LVL_W-1:0]      glv;
    logic [SLOT_W-1:0]     aidx;
    logic [ADDR_BITS-1:0]  abase;
    logic [MASK_W-1:0]     upmask;

    // allocate decode: size check and target level
    always_comb begin
        pool_bytes = (ADDR_BITS+1)'(1) << i_cfg.pool_log2;
        need       = (ADDR_BITS+1)'(i_request_length) + (ADDR_BITS+1)'(i_cfg.hdr);
        too_large  = need > pool_bytes;
        tgt        = '0;
        for (int t = 0; t < MASK_W; t++) begin
            if ((LVL_W'(t) <= i_cfg.lmax)
                && (((ADDR_BITS+1)'(1) << (i_cfg.pool_log2 - LOG_W'(t))) >= need)) begin
                tgt = LVL_W'(t);
            end
        end
    end

    // free decode: offset checks
    always_comb begin
        fbase = i_data_offset - ADDR_BITS'(i_cfg.hdr);
        fslot = SLOT_W'(fbase >> i_cfg.min_log2);
        fbad  = (i_data_offset < ADDR_BITS'(i_cfg.hdr))
              || ((ADDR_BITS+1)'(fbase) >= pool_bytes)
              || ((fbase & ~(ADDR_BITS'({ADDR_BITS{1'b1}}) << i_cfg.min_log2)) != '0);
    end

    // deepest free level at or above target, from the root summary
    always_comb begin
        fnd     = '0;
        fnd_any = 1'b0;
        for (int l = 0; l < MASK_W; l++) begin
            if ((LVL_W'(l) <= r_target) && i_mark_rdata[l]) begin
                fnd     = LVL_W'(l);
                fnd_any = 1'b1;
            end
        end
    end

    assign glv    = LVL_W'(i_gl_rdata - GL_W'(1));
    assign aidx   = SLOT_W'(r_node - (NODE_W'(1) << r_lv));
    assign abase  = ADDR_BITS'(aidx) << (i_cfg.pool_log2 - LOG_W'(r_target));
    assign upmask = r_cur | i_mark_rdata;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_node    = r_node;
        n_fnode   = r_fnode;
        n_lv      = r_lv;
        n_target  = r_target;
        n_found   = r_found;
        n_cur     = r_cur;
        n_base    = r_base;
        n_slot    = r_slot;
        n_res_off = r_res_off;
        n_done    = 1'b0;
        n_status  = r_status;
        n_off     = r_off;
        o_mark    = '{we: 1'b0, waddr: r_node, wdata: '0, raddr: NODE_W'(1)};
        o_gl      = '{we: 1'b0, waddr: r_slot, wdata: '0, raddr: fslot};
        case (r_state)
            S_CLR: begin
                o_mark.we    = 1'b1;
                o_mark.waddr = r_cnt;
                o_mark.wdata = (r_cnt == NODE_W'(1)) ? MASK_W'(1) : '0;
                o_gl.we      = 1'b1;
                o_gl.waddr   = r_cnt[SLOT_W-1:0];
                n_cnt        = r_cnt + NODE_W'(1);
                if (r_cnt == NODE_W'(MARK_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_ALLOC) begin
                        n_target = tgt;
                        if (too_large) begin
                            n_done   = 1'b1;
                            n_status = ST_TOO_LARGE;
                            n_off    = '0;
                        end else begin
                            n_state = S_A_CHK;
                        end
                    end else begin
                        n_base = fbase;
                        n_slot = fslot;
                        if (fbad) begin
                            n_done   = 1'b1;
                            n_status = ST_BAD_FREE;
                            n_off    = '0;
                        end else begin
                            n_state = S_F_CHK;
                        end
                    end
                end
            end
            S_A_CHK: begin
                n_node  = NODE_W'(1);
                n_lv    = '0;
                n_found = fnd;
                if (!fnd_any) begin
                    n_done   = 1'b1;
                    n_status = ST_NO_SPACE;
                    n_off    = '0;
                    n_state  = S_IDLE;
                end else if (fnd == '0) begin
                    n_fnode = NODE_W'(1);
                    n_state = S_S_WC;
                end else begin
                    n_state = S_D_RD;
                end
            end
            S_D_RD: begin
                o_mark.raddr = r_node << 1;
                n_state      = S_D_CHK;
            end
            S_D_CHK: begin
                // go left when the left subtree has a free block at that level
                n_node = i_mark_rdata[r_found] ? (r_node << 1) : ((r_node << 1) | NODE_W'(1));
                n_lv   = r_lv + LVL_W'(1);
                if (r_lv + LVL_W'(1) == r_found) begin
                    n_fnode = n_node;
                    n_state = S_S_WC;
                end else begin
                    n_state = S_D_RD;
                end
            end
            S_S_WC: begin
                o_mark.we    = 1'b1;
                o_mark.waddr = r_node;
                o_mark.wdata = chain_mask(r_lv, r_target);
                if (r_lv == r_target) begin
                    o_gl.we    = 1'b1;
                    o_gl.waddr = SLOT_W'(abase >> i_cfg.min_log2);
                    o_gl.wdata = GL_W'(r_target) + GL_W'(1);
                    n_res_off  = abase + ADDR_BITS'(i_cfg.hdr);
                    n_node     = r_fnode;
                    n_cur      = chain_mask(r_found, r_target);
                    n_state    = S_U_RD;
                end else begin
                    n_state = S_S_WS;
                end
            end
            S_S_WS: begin
                // upper half of the split is free
                o_mark.we    = 1'b1;
                o_mark.waddr = (r_node << 1) | NODE_W'(1);
                o_mark.wdata = MASK_W'(1) << (r_lv + LVL_W'(1));
                n_node       = r_node << 1;
                n_lv         = r_lv + LVL_W'(1);
                n_state      = S_S_WC;
            end
            S_F_CHK: begin
                o_gl.raddr = r_slot;
                if ((i_gl_rdata == '0) || (i_gl_rdata > GL_W'(i_cfg.lmax) + GL_W'(1))) begin
                    n_done   = 1'b1;
                    n_status = ST_BAD_FREE;
                    n_off    = '0;
                    n_state  = S_IDLE;
                end else begin
                    o_gl.we    = 1'b1;
                    o_gl.waddr = r_slot;
                    n_lv       = glv;
                    n_node     = (NODE_W'(1) << glv)
                               | NODE_W'(r_base >> (i_cfg.pool_log2 - LOG_W'(glv)));
                    n_res_off  = '0;
                    n_state    = S_M_RD;
                end
            end
            S_M_RD: begin
                o_mark.raddr = r_node ^ NODE_W'(1);
                n_state      = (r_lv == '0) ? S_M_FIN : S_M_CHK;
            end
            S_M_CHK: begin
                if (i_mark_rdata[r_lv]) begin
                    // buddy free: absorb it
                    o_mark.we    = 1'b1;
                    o_mark.waddr = r_node ^ NODE_W'(1);
                    n_node       = r_node >> 1;
                    n_lv         = r_lv - LVL_W'(1);
                    n_state      = S_M_RD;
                end else begin
                    n_state = S_M_FIN;
                end
            end
            S_M_FIN: begin
                o_mark.we    = 1'b1;
                o_mark.waddr = r_node;
                o_mark.wdata = MASK_W'(1) << r_lv;
                n_cur        = MASK_W'(1) << r_lv;
                n_state      = S_U_RD;
            end
            S_U_RD: begin
                o_mark.raddr = r_node ^ NODE_W'(1);
                if (r_node == NODE_W'(1)) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_off    = r_res_off;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_U_WR;
                end
            end
            S_U_WR: begin
                // parent summary from this node and its sibling
                o_mark.we    = 1'b1;
                o_mark.waddr = r_node >> 1;
                o_mark.wdata = upmask;
                n_cur        = upmask;
                n_node       = r_node >> 1;
                n_state      = S_U_RD;
            end
            default: begin
                n_state = S_CLR;
                n_cnt   = '0;
            end
        endcase
        if (i_clear) begin
            n_state = S_CLR;
            n_cnt   = '0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_fnode   <= n_fnode;
        r_lv      <= n_lv;
        r_target  <= n_target;
        r_found   <= n_found;
        r_cur     <= n_cur;
        r_base    <= n_base;
        r_slot    <= n_slot;
        r_res_off <= n_res_off;
        r_status  <= n_status;
        r_off     <= n_off;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_offset = r_off;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer active");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status != ST_OK)) |-> (r_off == '0))
        else $error("failed request carries an offset");
    a_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U_WR) |-> (r_node != NODE_W'(1)))
        else $error("summary walk past root");
    a_split_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_S_WC) || (r_state == S_S_WS)) |-> (r_lv <= r_target))
        else $error("split walked below target level");
endmodule

FILE: rtl/buddy_block_allocator_unit.sv
// channel   | direction | ports
// ----------+-----------+---------------------------------------------------
// request   | in        | i_start, o_busy, i_opcode, i_request_length,
//           |           | i_data_offset (taken when i_start && !o_busy)
// result    | out       | o_done strobe, o_status, o_granted_offset
// config    | in        | i_cfg_we, i_cfg_idx, i_cfg_data
//
// the result strobe is registered: for a size or offset failure it is set from the
// idle state, for no space or an unrecorded free from the check state, and an
// allocate descends, splits and updates the summaries up to the root, while a free
// merges and updates them up to the root; the walk is paced by the node summary
// memory, one read and one write a cycle, with a registered read. o_busy drops in
// the strobe cycle. after reset and after a write to a valid config register a
// clearing pass over the node summary and level memories runs; o_busy is high
// during it. results show for one cycle; the receiver cannot stall.
module buddy_block_allocator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_opcode,
    input  logic [bba_pkg::ADDR_BITS-1:0]        i_request_length,
    input  logic [bba_pkg::ADDR_BITS-1:0]        i_data_offset,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic [bba_pkg::ADDR_BITS-1:0]        o_granted_offset,
    input  logic                                 i_cfg_we,
    input  logic [bba_pkg::CIDX_W-1:0]           i_cfg_idx,
    input  logic [bba_pkg::CDATA_W-1:0]          i_cfg_data
);
    import bba_pkg::*;

    logic [LOG_W-1:0]  r_pool_log2;
    logic [LOG_W-1:0]  r_min_log2;
    logic [HDR_W-1:0]  r_hdr;
    logic              clear;
    logic [LOG_W-1:0]  p, lo, m;
    t_cfg              cfg;
    t_mark_req         mark_req;
    t_gl_req           gl_req;
    logic [MASK_W-1:0] mark_rdata;
    logic [GL_W-1:0]   gl_rdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_log2 <= LOG_W'(20);
            r_min_log2  <= LOG_W'(8);
            r_hdr       <= HDR_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POOL_LOG2: r_pool_log2 <= i_cfg_data[LOG_W-1:0];
                REG_MIN_LOG2:  r_min_log2  <= i_cfg_data[LOG_W-1:0];
                REG_HEADER:    r_hdr       <= i_cfg_data[HDR_W-1:0];
                default:       ;
            endcase
        end
    end

    assign clear = i_cfg_we && ((i_cfg_idx == REG_POOL_LOG2) || (i_cfg_idx == REG_MIN_LOG2)
                                || (i_cfg_idx == REG_HEADER));

    // clamp pool and minimum block sizes
    always_comb begin
        p = r_pool_log2;
        if (p < LOG_W'(4)) p = LOG_W'(4);
        if (p > LOG_W'(ADDR_BITS)) p = LOG_W'(ADDR_BITS);
        lo = (p > LOG_W'(MAX_LEVELS)) ? p - LOG_W'(MAX_LEVELS) : '0;
        if (lo < LOG_W'(4)) lo = LOG_W'(4);
        m = r_min_log2;
        if (m < lo) m = lo;
        if (m > p) m = p;
        cfg.pool_log2 = p;
        cfg.min_log2  = m;
        cfg.lmax      = LVL_W'(p - m);
        cfg.hdr       = r_hdr;
    end

    bba_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_clear          (clear),
        .i_start          (i_start),
        .i_opcode         (i_opcode),
        .i_request_length (i_request_length),
        .i_data_offset    (i_data_offset),
        .o_busy           (o_busy),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_mark           (mark_req),
        .i_mark_rdata     (mark_rdata),
        .o_gl             (gl_req),
        .i_gl_rdata       (gl_rdata)
    );

    // per-node free summary: bit l set when the subtree holds a free block at level l
    bba_ram #(.W(MASK_W), .D(MARK_DEPTH)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_req.we),
        .i_waddr (mark_req.waddr),
        .i_wdata (mark_req.wdata),
        .i_raddr (mark_req.raddr),
        .o_rdata (mark_rdata)
    );

    // level + 1 of each granted block, by base slot
    bba_ram #(.W(GL_W), .D(GL_DEPTH)) u_gl_ram (
        .i_clk   (i_clk),
        .i_we    (gl_req.we),
        .i_waddr (gl_req.waddr),
        .i_wdata (gl_req.wdata),
        .i_raddr (gl_req.raddr),
        .o_rdata (gl_rdata)
    );
endmodule

FILE: bench/tb_buddy_block_allocator_unit.sv
`timescale 1ns / 100ps

module tb_buddy_block_allocator_unit;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 100;

    // register index past the list, ignored by the block
    localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;

    typedef enum int { K_REQ, K_CFG, K_MODE, K_DRAIN } t_item_kind;

    typedef struct {
        t_status              st;
        logic [ADDR_BITS-1:0] goff;
    } t_grant;

    typedef struct {
        t_item_kind           kind;
        logic                 op;
        logic [ADDR_BITS-1:0] len;
        logic [ADDR_BITS-1:0] off;
        logic [CIDX_W-1:0]    cidx;
        logic [CDATA_W-1:0]   cdata;
        int                   pct;
        t_grant               grant;
    } t_pending;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 i_opcode = 1'b0;
    logic [ADDR_BITS-1:0] i_request_length = '0;
    logic [ADDR_BITS-1:0] i_data_offset = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]    i_cfg_idx = '0;
    logic [CDATA_W-1:0]   i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [1:0]           o_status;
    logic [ADDR_BITS-1:0] o_granted_offset;

    buddy_block_allocator_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // allocator state mirror
    bit                   tree_free [0:MARK_DEPTH-1];
    logic [GL_W-1:0]      slot_level [0:GL_DEPTH-1];
    int                   cfg_pool = 20;
    int                   cfg_min  = 8;
    int                   cfg_hdr  = 16;

    t_pending             request_q [$];
    t_grant               grant_q [$];
    logic [ADDR_BITS-1:0] live_offsets [$];
    int                   mismatches = 0;
    bit                   failed = 1'b0;

    function automatic int pool_log2();
        int p;
        p = cfg_pool;
        if (p < 4) p = 4;
        if (p > ADDR_BITS) p = ADDR_BITS;
        return p;
    endfunction

    function automatic int min_log2(int p);
        int m;
        int lo;
        m = cfg_min;
        lo = (p > MAX_LEVELS) ? p - MAX_LEVELS : 0;
        if (lo < 4) lo = 4;
        if (m < lo) m = lo;
        if (m > p) m = p;
        return m;
    endfunction

    function automatic void clear_tree();
        foreach (tree_free[k]) tree_free[k] = 1'b0;
        foreach (slot_level[k]) slot_level[k] = '0;
        tree_free[1] = 1'b1;
    endfunction

    function automatic t_grant predict_alloc(logic [ADDR_BITS-1:0] len);
        t_grant g;
        int p, m, target, found, lv, idx;
        longint need, base;
        g.st = ST_OK;
        g.goff = '0;
        p = pool_log2();
        m = min_log2(p);
        need = longint'(len) + cfg_hdr;
        target = p - m;
        found = -1;
        idx = 0;
        if (need > (64'd1 << p)) begin
            g.st = ST_TOO_LARGE;
            return g;
        end
        while (target > 0 && (64'd1 << (p - target)) < need) target--;
        for (lv = target; lv >= 0 && found < 0; lv--) begin
            for (int i = 0; i < (1 << lv); i++) begin
                if (tree_free[(1 << lv) + i]) begin
                    found = lv;
                    idx = i;
                    break;
                end
            end
        end
        if (found < 0) begin
            g.st = ST_NO_SPACE;
            return g;
        end
        // take the block, then split down keeping the lower half
        lv = found;
        tree_free[(1 << lv) + idx] = 1'b0;
        while (lv < target) begin
            lv++;
            idx = idx << 1;
            tree_free[(1 << lv) + idx + 1] = 1'b1;
        end
        base = longint'(idx) << (p - target);
        slot_level[(base >> m) & (GL_DEPTH - 1)] = GL_W'(target + 1);
        g.goff = ADDR_BITS'(base + cfg_hdr);
        return g;
    endfunction

    function automatic t_grant predict_free(logic [ADDR_BITS-1:0] off);
        t_grant g;
        int p, m, lv, idx, slot;
        longint base;
        g.st = ST_BAD_FREE;
        g.goff = '0;
        p = pool_log2();
        m = min_log2(p);
        if (longint'(off) < cfg_hdr) return g;
        base = longint'(off) - cfg_hdr;
        if (base >= (64'd1 << p) || (base & ((64'd1 << m) - 1)) != 0) return g;
        slot = int'((base >> m) & (GL_DEPTH - 1));
        if (slot_level[slot] == 0 || slot_level[slot] > p - m + 1) return g;
        lv = slot_level[slot] - 1;
        slot_level[slot] = '0;
        idx = int'(base >> (p - lv));
        // merge upward while the buddy is free
        while (lv > 0 && tree_free[(1 << lv) + (idx ^ 1)]) begin
            tree_free[(1 << lv) + (idx ^ 1)] = 1'b0;
            idx = idx >> 1;
            lv--;
        end
        tree_free[(1 << lv) + idx] = 1'b1;
        g.st = ST_OK;
        return g;
    endfunction

    function automatic void add_request(logic op, logic [ADDR_BITS-1:0] len,
                                        logic [ADDR_BITS-1:0] off);
        t_pending it;
        it = '{kind: K_REQ, op: op, len: len, off: off, cidx: '0, cdata: '0, pct: 0,
               grant: '{st: ST_OK, goff: '0}};
        if (op == OP_ALLOC) begin
            it.grant = predict_alloc(len);
            if (it.grant.st == ST_OK) live_offsets.push_back(it.grant.goff);
        end else begin
            it.grant = predict_free(off);
            if (it.grant.st == ST_OK) begin
                foreach (live_offsets[k]) begin
                    if (live_offsets[k] == off) begin
                        live_offsets.delete(k);
                        break;
                    end
                end
            end
        end
        request_q.push_back(it);
    endfunction

    function automatic void add_control(t_item_kind kind, logic [CIDX_W-1:0] cidx,
                                        logic [CDATA_W-1:0] cdata, int pct);
        t_pending it;
        it = '{kind: kind, op: OP_ALLOC, len: '0, off: '0, cidx: cidx, cdata: cdata,
               pct: pct, grant: '{st: ST_OK, goff: '0}};
        if (kind == K_CFG && cidx != REG_NONE) begin
            if (cidx == REG_POOL_LOG2) cfg_pool = cdata & 7'h1f;
            else if (cidx == REG_MIN_LOG2) cfg_min = cdata & 7'h1f;
            else cfg_hdr = cdata;
            clear_tree();
            live_offsets.delete();
        end
        request_q.push_back(it);
    endfunction

    function automatic void set_config(int p, int m, int h);
        add_control(K_CFG, REG_POOL_LOG2, CDATA_W'(p), 0);
        add_control(K_CFG, REG_MIN_LOG2, CDATA_W'(m), 0);
        add_control(K_CFG, REG_HEADER, CDATA_W'(h), 0);
    endfunction

    // random traffic biased toward allocations that fit and frees of live blocks
    function automatic void add_random(int count);
        logic [ADDR_BITS-1:0] len, off;
        int p;
        for (int n = 0; n < count; n++) begin
            p = pool_log2();
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(19) == 0) len = ADDR_BITS'($urandom);
                else len = ADDR_BITS'($urandom_range(0, (1 << $urandom_range(0, p)) - 1));
                add_request(OP_ALLOC, len, ADDR_BITS'($urandom));
            end else begin
                if (live_offsets.size() > 0 && $urandom_range(99) < 75)
                    off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
                else if ($urandom_range(1) == 0)
                    off = ADDR_BITS'($urandom);
                else
                    off = ADDR_BITS'(($urandom_range(0, (1 << p) - 1) & ~32'hf) + cfg_hdr);
                add_request(OP_FREE, ADDR_BITS'($urandom), off);
            end
        end
    endfunction

    // request driver
    t_pending cur;
    int       idle_pct = 0;
    int       hold = 0;
    always @(posedge i_clk) begin
        logic st, we;
        st = i_start;
        we = 1'b0;
        if (!i_rst_n) begin
            st = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                grant_q.push_back(cur.grant);
                st = 1'b0;
            end
            if (!st) begin
                if (hold > 0) begin
                    hold--;
                end else if (request_q.size() > 0) begin
                    case (request_q[0].kind)
                        K_REQ: begin
                            if ($urandom_range(99) >= idle_pct) begin
                                cur = request_q.pop_front();
                                st = 1'b1;
                                i_opcode <= cur.op;
                                i_request_length <= cur.len;
                                i_data_offset <= cur.off;
                            end
                        end
                        K_MODE: begin
                            idle_pct = request_q.pop_front().pct;
                        end
                        default: begin
                            if (grant_q.size() == 0 && !o_busy && !i_start) begin
                                cur = request_q.pop_front();
                                if (cur.kind == K_CFG) begin
                                    we = 1'b1;
                                    i_cfg_idx <= cur.cidx;
                                    i_cfg_data <= cur.cdata;
                                end
                                hold = 4;
                            end
                        end
                    endcase
                end
            end
        end
        i_start <= st;
        i_cfg_we <= we;
    end

    // result checker
    always @(posedge i_clk) begin
        t_grant e;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d", o_status);
            end else begin
                e = grant_q.pop_front();
                if (o_status !== e.st || o_granted_offset !== e.goff) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d offset=%h, got %0d %h",
                                 e.st, e.goff, o_status, o_granted_offset);
                end
            end
        end
    end

    // watchdog on cycles without progress
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || i_cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        clear_tree();
        // directed: reset configuration
        add_request(OP_ALLOC, '0, '0);
        add_request(OP_ALLOC, 20'hfffff, '0);
        add_request(OP_FREE, '0, 20'd16);
        add_request(OP_FREE, '0, 20'd16);
        add_request(OP_FREE, '0, 20'd3);
        add_request(OP_FREE, '0, 20'd17);
        add_request(OP_ALLOC, 20'd1048560, '0);
        add_request(OP_ALLOC, 20'd1, '0);
        add_request(OP_FREE, '0, 20'd16);
        add_request(OP_ALLOC, 20'd240, '0);
        add_request(OP_ALLOC, 20'd241, '0);
        add_request(OP_FREE, '0, 20'hfffff);
        add_control(K_DRAIN, '0, '0, 0);
        // ignored register index must not clear the tree
        add_control(K_CFG, REG_NONE, 7'h7f, 0);
        add_request(OP_FREE, '0, 20'd16);
        // smallest pool: one block only
        set_config(0, 31, 0);
        add_request(OP_ALLOC, 20'd16, '0);
        add_request(OP_ALLOC, 20'd17, '0);
        add_request(OP_ALLOC, 20'd0, '0);
        add_request(OP_ALLOC, 20'd0, '0);
        add_request(OP_FREE, '0, 20'd0);
        add_request(OP_FREE, '0, 20'd16);
        set_config(31, 0, 64);
        add_request(OP_ALLOC, 20'd0, '0);
        add_request(OP_FREE, '0, 20'd64);
        // random phases across settings and idle rates
        add_control(K_MODE, '0, '0, 0);
        set_config(20, 8, 16);
        add_random(250);
        add_control(K_MODE, '0, '0, 53);
        add_random(150);
        add_control(K_DRAIN, '0, '0, 0);
        add_random(100);
        set_config(10, 4, 0);
        add_control(K_MODE, '0, '0, 23);
        add_random(250);
        set_config(16, 4, 64);
        add_control(K_MODE, '0, '0, 0);
        add_random(250);
        set_config(8, 6, 5);
        add_control(K_MODE, '0, '0, 53);
        add_random(200);
        set_config(20, 20, 64);
        add_random(50);
        set_config(12, 7, 33);
        add_control(K_MODE, '0, '0, 0);
        add_random(250);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (request_q.size() == 0 && grant_q.size() == 0 && !i_start);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        // every expected result must have come
        if (grant_q.size() != 0) failed = 1'b1;
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_unit.sv
bench/tb_buddy_block_allocator_unit.sv
